@@ src/mkuf_pkg.sv @@
// ---------------------------------------------------------------------------
// mkuf_pkg
// Shared widths and reset values for the spanning-tree block and its checker.
// ---------------------------------------------------------------------------
`default_nettype none

package mkuf_pkg;

  localparam int unsigned NODE_COUNT_W   = 5;   // cfg_node_count width
  localparam int unsigned IN_WEIGHT_W    = 16;  // in_weight width
  localparam int unsigned OUT_NODE_W     = 4;   // out_from_node / out_to_node width
  localparam int unsigned OUT_WEIGHT_W   = 16;  // out_edge_weight width
  localparam int unsigned RANK_W         = 3;   // union-by-rank counter width

  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 5'd16;

endpackage

`default_nettype wire

@@ src/mst_kruskal_union_find.sv @@
// ---------------------------------------------------------------------------
// mst_kruskal_union_find
// Streams in an adjacency matrix, then emits a minimum spanning forest
// (Kruskal order, union-find with path compression and union by rank).
// ---------------------------------------------------------------------------
//
//  channel | signals                                   | flow
//  --------+-------------------------------------------+--------------------------
//  in      | in_valid/in_ready, in_weight              | one matrix entry / request
//  out     | out_valid/out_ready, out_from_node,       | one forest edge / request
//          | out_to_node, out_edge_weight,             |
//          | out_edge_valid, out_last                  |
//  cfg     | cfg_we, cfg_node_count                    | write-only, no wait
//
//  Matrix entries load at one per cycle while in_ready is high. A cfg write
//  drops in_ready while row/column are rederived by a bit-serial divider.
//  After the final entry the run takes, per candidate edge, one full scan
//  of the edge memory through its single read port, plus a union-find walk
//  over every path step. in_ready stays low until the last result sits
//  in the output register. Output stalls only hold the run at a push or at
//  the final result.
//  rst_n is synchronous; union-find entries reset via per-entry valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

module mst_kruskal_union_find #(
  parameter int unsigned MAX_NODES   = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // matrix entries
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [mkuf_pkg::IN_WEIGHT_W-1:0]     in_weight,
  // forest edges
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [mkuf_pkg::OUT_NODE_W-1:0]           out_from_node,
  output logic [mkuf_pkg::OUT_NODE_W-1:0]           out_to_node,
  output logic [mkuf_pkg::OUT_WEIGHT_W-1:0]         out_edge_weight,
  output logic                                      out_edge_valid,
  output logic                                      out_last,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [mkuf_pkg::NODE_COUNT_W-1:0]    cfg_node_count
);

  localparam int unsigned NCW       = mkuf_pkg::NODE_COUNT_W;
  localparam int unsigned RKW       = mkuf_pkg::RANK_W;
  localparam int unsigned WB        = WEIGHT_BITS;
  // node_count is 5 bits wide, so the usable node count also caps at 31
  localparam int unsigned NMAX      = (MAX_NODES > 31) ? 31 : MAX_NODES;
  localparam int unsigned NW        = $clog2(MAX_NODES);
  localparam int unsigned MAX_EDGES = (MAX_NODES * (MAX_NODES - 1)) / 2;
  localparam int unsigned EI_W      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EC_W      = $clog2(MAX_EDGES + 1);
  localparam int unsigned LP_W      = $clog2(NMAX * NMAX);
  localparam int unsigned DC_W      = $clog2(LP_W);
  localparam int unsigned SQ_W      = 2 * NCW;
  localparam int unsigned CMP_W     = SQ_W + LP_W + 1;
  localparam int unsigned CNT_W     = $clog2(MAX_NODES);
  localparam int unsigned EM_W      = WB + 2 * NW;

  typedef enum logic [3:0] {
    S_LOAD, S_DIV, S_SCAN, S_FISS, S_FCHK, S_CISS, S_CWR,
    S_JOIN, S_JRANK, S_PUSH, S_FIN
  } state_t;

  typedef struct packed {
    logic [NW-1:0]  parent;
    logic [RKW-1:0] rank;
  } uf_ent_t;

  // ---------------- registers ----------------
  state_t                 state_r, state_nxt;
  logic [NCW-1:0]         ncount_r, ncount_nxt;
  logic [LP_W-1:0]        lp_r, lp_nxt;
  logic [LP_W-1:0]        row_r, row_nxt;
  logic [NCW-1:0]         col_r, col_nxt;
  logic [EC_W-1:0]        ec_r, ec_nxt;
  // divider
  logic [DC_W-1:0]        dcnt_r, dcnt_nxt;
  logic [LP_W-1:0]        dsh_r, dsh_nxt;
  logic [LP_W-1:0]        quo_r, quo_nxt;
  logic [NCW-1:0]         rem_r, rem_nxt;
  // selection scan
  logic [EC_W-1:0]        scan_i_r, scan_i_nxt;
  logic                   dv_r, dv_nxt;
  logic [EI_W-1:0]        didx_r, didx_nxt;
  logic                   first_r, first_nxt;
  logic [WB-1:0]          pw_r, pw_nxt;
  logic [EI_W-1:0]        pidx_r, pidx_nxt;
  logic                   found_r, found_nxt;
  logic [WB-1:0]          bw_r, bw_nxt;
  logic [NW-1:0]          blo_r, blo_nxt;
  logic [NW-1:0]          bhi_r, bhi_nxt;
  logic [EI_W-1:0]        bidx_r, bidx_nxt;
  // union-find walk
  logic [NW-1:0]          cur_r, cur_nxt;
  logic                   which_r, which_nxt;
  logic [NW-1:0]          root_r, root_nxt;
  logic [NW-1:0]          ra_r, ra_nxt;
  logic [RKW-1:0]         rka_r, rka_nxt;
  logic [RKW-1:0]         rkb_r, rkb_nxt;
  logic [MAX_NODES-1:0]   uf_vld_r, uf_vld_nxt;
  // held result and output register
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [NW-1:0]          pend_lo_r, pend_lo_nxt;
  logic [NW-1:0]          pend_hi_r, pend_hi_nxt;
  logic [WB-1:0]          pend_w_r, pend_w_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [NW-1:0]          out_lo_r, out_lo_nxt;
  logic [NW-1:0]          out_hi_r, out_hi_nxt;
  logic [WB-1:0]          out_w_r, out_w_nxt;
  logic                   out_ev_r, out_ev_nxt;
  logic                   out_last_r, out_last_nxt;

  // ---------------- memories ----------------
  logic [EM_W-1:0]        edge_mem [MAX_EDGES];
  logic                   em_we;
  logic [EI_W-1:0]        em_waddr, em_raddr;
  logic [EM_W-1:0]        em_wdata, em_q_r;

  uf_ent_t                uf_mem [MAX_NODES];
  logic                   uf_we;
  logic [NW-1:0]          uf_waddr, uf_raddr;
  uf_ent_t                uf_wdata, uf_q_r;
  logic                   uf_qv_r;

  always_ff @(posedge clk) begin
    if (em_we) begin
      edge_mem[em_waddr] <= em_wdata;
    end
    em_q_r <= edge_mem[em_raddr];
  end

  always_ff @(posedge clk) begin
    if (uf_we) begin
      uf_mem[uf_waddr] <= uf_wdata;
    end
    uf_q_r  <= uf_mem[uf_raddr];
    uf_qv_r <= uf_vld_r[uf_raddr];
  end

  // ---------------- datapath helpers ----------------
  logic [NCW-1:0]   neff;
  logic [SQ_W-1:0]  nsq;
  logic [WB-1:0]    w_in;
  logic             in_fire, is_final, keep_edge, slot_free;
  logic [NCW:0]     rem2;
  logic [WB-1:0]    qw;
  logic [NW-1:0]    qlo, qhi;
  logic             cand;
  logic [NW-1:0]    fpar;
  logic [RKW-1:0]   frk;

  // zero counts as one node; above the cap saturates
  always_comb begin
    if (ncount_r == '0) begin
      neff = NCW'(1);
    end else if (ncount_r > NCW'(NMAX)) begin
      neff = NCW'(NMAX);
    end else begin
      neff = ncount_r;
    end
  end

  assign nsq       = SQ_W'(neff) * SQ_W'(neff);
  assign w_in      = WB'(in_weight);
  assign in_ready  = (state_r == S_LOAD) && !cfg_we;
  assign in_fire   = in_valid && in_ready;
  assign is_final  = (CMP_W'(lp_r) + CMP_W'(1)) >= CMP_W'(nsq);
  assign keep_edge = (CMP_W'(col_r) > CMP_W'(row_r)) && (w_in != '0) &&
                     (ec_r < EC_W'(MAX_EDGES));
  assign slot_free = !out_valid_r || out_ready;
  assign rem2      = {rem_r, dsh_r[LP_W-1]};
  assign {qw, qlo, qhi} = em_q_r;
  // stable order: strictly after the previous pick in (weight, index)
  assign cand      = first_r || (qw > pw_r) || ((qw == pw_r) && (didx_r > pidx_r));
  // an entry never written since run start is its own root with rank 0
  assign fpar      = uf_qv_r ? uf_q_r.parent : cur_r;
  assign frk       = uf_qv_r ? uf_q_r.rank : '0;

  assign em_wdata  = {w_in, NW'(row_r), NW'(col_r)};
  assign em_waddr  = ec_r[EI_W-1:0];
  assign em_we     = in_fire && keep_edge;
  assign em_raddr  = scan_i_r[EI_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    ncount_nxt    = cfg_we ? cfg_node_count : ncount_r;
    lp_nxt        = lp_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ec_nxt        = ec_r;
    dcnt_nxt      = dcnt_r;
    dsh_nxt       = dsh_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    scan_i_nxt    = scan_i_r;
    dv_nxt        = 1'b0;
    didx_nxt      = didx_r;
    first_nxt     = first_r;
    pw_nxt        = pw_r;
    pidx_nxt      = pidx_r;
    found_nxt     = found_r;
    bw_nxt        = bw_r;
    blo_nxt       = blo_r;
    bhi_nxt       = bhi_r;
    bidx_nxt      = bidx_r;
    cur_nxt       = cur_r;
    which_nxt     = which_r;
    root_nxt      = root_r;
    ra_nxt        = ra_r;
    rka_nxt       = rka_r;
    rkb_nxt       = rkb_r;
    uf_vld_nxt    = uf_vld_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_lo_nxt   = pend_lo_r;
    pend_hi_nxt   = pend_hi_r;
    pend_w_nxt    = pend_w_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_lo_nxt    = out_lo_r;
    out_hi_nxt    = out_hi_r;
    out_w_nxt     = out_w_r;
    out_ev_nxt    = out_ev_r;
    out_last_nxt  = out_last_r;
    uf_we         = 1'b0;
    uf_waddr      = cur_r;
    uf_wdata      = '{parent: root_r, rank: frk};
    uf_raddr      = cur_r;

    unique case (state_r)
      S_LOAD: begin
        if (cfg_we) begin
          state_nxt = S_DIV;
          dcnt_nxt  = '0;
          dsh_nxt   = lp_r;
          quo_nxt   = '0;
          rem_nxt   = '0;
        end else if (in_fire) begin
          if (keep_edge) begin
            ec_nxt = ec_r + EC_W'(1);
          end
          if (is_final) begin
            lp_nxt     = '0;
            row_nxt    = '0;
            col_nxt    = '0;
            uf_vld_nxt = '0;
            cnt_nxt    = '0;
            pend_v_nxt = 1'b0;
            first_nxt  = 1'b1;
            found_nxt  = 1'b0;
            scan_i_nxt = '0;
            state_nxt  = S_SCAN;
          end else begin
            lp_nxt = lp_r + LP_W'(1);
            if (col_r + NCW'(1) == neff) begin
              col_nxt = '0;
              row_nxt = row_r + LP_W'(1);
            end else begin
              col_nxt = col_r + NCW'(1);
            end
          end
        end
      end

      // restoring division of load position by the node count
      S_DIV: begin
        if (cfg_we) begin
          dcnt_nxt = '0;
          dsh_nxt  = lp_r;
          quo_nxt  = '0;
          rem_nxt  = '0;
        end else begin
          dsh_nxt = dsh_r << 1;
          if (rem2 >= (NCW+1)'(neff)) begin
            rem_nxt = NCW'(rem2 - (NCW+1)'(neff));
            quo_nxt = {quo_r[LP_W-2:0], 1'b1};
          end else begin
            rem_nxt = NCW'(rem2);
            quo_nxt = {quo_r[LP_W-2:0], 1'b0};
          end
          dcnt_nxt = dcnt_r + DC_W'(1);
          if (dcnt_r == DC_W'(LP_W - 1)) begin
            row_nxt   = quo_nxt;
            col_nxt   = rem_nxt;
            state_nxt = S_LOAD;
          end
        end
      end

      // one read per cycle; pick the smallest (weight, index) after the last pick
      S_SCAN: begin
        if (scan_i_r < ec_r) begin
          scan_i_nxt = scan_i_r + EC_W'(1);
          dv_nxt     = 1'b1;
          didx_nxt   = scan_i_r[EI_W-1:0];
        end
        if (dv_r && cand && (!found_r || (qw < bw_r))) begin
          found_nxt = 1'b1;
          bw_nxt    = qw;
          blo_nxt   = qlo;
          bhi_nxt   = qhi;
          bidx_nxt  = didx_r;
        end
        if ((scan_i_r >= ec_r) && !dv_r) begin
          if (found_r) begin
            first_nxt = 1'b0;
            pw_nxt    = bw_r;
            pidx_nxt  = bidx_r;
            cur_nxt   = blo_r;
            which_nxt = 1'b0;
            state_nxt = S_FISS;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_FISS: begin
        state_nxt = S_FCHK;
      end

      S_FCHK: begin
        if (fpar == cur_r) begin
          root_nxt = cur_r;
          if (which_r) begin
            rkb_nxt = frk;
            cur_nxt = bhi_r;
          end else begin
            rka_nxt = frk;
            cur_nxt = blo_r;
          end
          state_nxt = S_CISS;
        end else begin
          cur_nxt   = fpar;
          state_nxt = S_FISS;
        end
      end

      // path compression walk
      S_CISS: begin
        if (cur_r == root_r) begin
          if (!which_r) begin
            ra_nxt    = root_r;
            which_nxt = 1'b1;
            cur_nxt   = bhi_r;
            state_nxt = S_FISS;
          end else begin
            state_nxt = S_JOIN;
          end
        end else begin
          state_nxt = S_CWR;
        end
      end

      S_CWR: begin
        uf_we                = 1'b1;
        uf_vld_nxt[cur_r]    = 1'b1;
        cur_nxt              = fpar;
        state_nxt            = S_CISS;
      end

      S_JOIN: begin
        found_nxt  = 1'b0;
        scan_i_nxt = '0;
        if (ra_r == root_r) begin
          state_nxt = S_SCAN;
        end else if (rka_r > rkb_r) begin
          uf_we                = 1'b1;
          uf_waddr             = root_r;
          uf_wdata             = '{parent: ra_r, rank: rkb_r};
          uf_vld_nxt[root_r]   = 1'b1;
          state_nxt            = S_PUSH;
        end else begin
          uf_we                = 1'b1;
          uf_waddr             = ra_r;
          uf_wdata             = '{parent: root_r, rank: rka_r};
          uf_vld_nxt[ra_r]     = 1'b1;
          state_nxt            = (rka_r == rkb_r) ? S_JRANK : S_PUSH;
        end
      end

      S_JRANK: begin
        uf_we              = 1'b1;
        uf_waddr           = root_r;
        uf_wdata           = '{parent: root_r, rank: rkb_r + RKW'(1)};
        uf_vld_nxt[root_r] = 1'b1;
        state_nxt          = S_PUSH;
      end

      // the accepted edge is held until the next one shows it is not last
      S_PUSH: begin
        if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_lo_nxt    = pend_lo_r;
            out_hi_nxt    = pend_hi_r;
            out_w_nxt     = pend_w_r;
            out_ev_nxt    = 1'b1;
            out_last_nxt  = 1'b0;
          end
          pend_v_nxt  = 1'b1;
          pend_lo_nxt = blo_r;
          pend_hi_nxt = bhi_r;
          pend_w_nxt  = bw_r;
          cnt_nxt     = cnt_r + CNT_W'(1);
          state_nxt   = (cnt_nxt == CNT_W'(MAX_NODES - 1)) ? S_FIN : S_SCAN;
        end
      end

      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_lo_nxt    = pend_v_r ? pend_lo_r : '0;
          out_hi_nxt    = pend_v_r ? pend_hi_r : '0;
          out_w_nxt     = pend_v_r ? pend_w_r : '0;
          out_ev_nxt    = pend_v_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          ec_nxt        = '0;
          state_nxt     = S_LOAD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // walk reads always address the current node
    if (state_r == S_FISS || state_r == S_CISS) begin
      uf_raddr = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      ncount_r    <= mkuf_pkg::NODE_COUNT_RST;
      lp_r        <= '0;
      row_r       <= '0;
      col_r       <= '0;
      ec_r        <= '0;
      dv_r        <= 1'b0;
      uf_vld_r    <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ncount_r    <= ncount_nxt;
      lp_r        <= lp_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      ec_r        <= ec_nxt;
      dv_r        <= dv_nxt;
      uf_vld_r    <= uf_vld_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dcnt_r     <= dcnt_nxt;
    dsh_r      <= dsh_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    scan_i_r   <= scan_i_nxt;
    didx_r     <= didx_nxt;
    first_r    <= first_nxt;
    pw_r       <= pw_nxt;
    pidx_r     <= pidx_nxt;
    found_r    <= found_nxt;
    bw_r       <= bw_nxt;
    blo_r      <= blo_nxt;
    bhi_r      <= bhi_nxt;
    bidx_r     <= bidx_nxt;
    cur_r      <= cur_nxt;
    which_r    <= which_nxt;
    root_r     <= root_nxt;
    ra_r       <= ra_nxt;
    rka_r      <= rka_nxt;
    rkb_r      <= rkb_nxt;
    pend_lo_r  <= pend_lo_nxt;
    pend_hi_r  <= pend_hi_nxt;
    pend_w_r   <= pend_w_nxt;
    out_lo_r   <= out_lo_nxt;
    out_hi_r   <= out_hi_nxt;
    out_w_r    <= out_w_nxt;
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_from_node   = mkuf_pkg::OUT_NODE_W'(out_lo_r);
  assign out_to_node     = mkuf_pkg::OUT_NODE_W'(out_hi_r);
  assign out_edge_weight = mkuf_pkg::OUT_WEIGHT_W'(out_w_r);
  assign out_edge_valid  = out_ev_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

@@ src/mkuf_checker.sv @@
// ---------------------------------------------------------------------------
// mkuf_checker
// Port-level checks on the spanning-tree block's result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module mkuf_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic [mkuf_pkg::OUT_NODE_W-1:0]      out_from_node,
  input wire logic [mkuf_pkg::OUT_NODE_W-1:0]      out_to_node,
  input wire logic [mkuf_pkg::OUT_WEIGHT_W-1:0]    out_edge_weight,
  input wire logic                                 out_edge_valid,
  input wire logic                                 out_last
);

  // nothing pending out of reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // held result stays valid; its weight and last flag do not move
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_edge_weight) && $stable(out_last))
    else $error("stalled result changed");

  // empty-tree marker is always the whole run
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_edge_valid |-> out_last && out_edge_weight == '0)
    else $error("bad empty-tree marker");

  // a forest edge runs row to higher column, nonzero weight
  a_edge_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_valid |-> out_from_node < out_to_node && out_edge_weight != '0)
    else $error("malformed edge");

  // no new matrix while a run still has results to hand out
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a run");

endmodule

bind mst_kruskal_union_find mkuf_checker u_mkuf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_from_node  (out_from_node),
  .out_to_node    (out_to_node),
  .out_edge_weight(out_edge_weight),
  .out_edge_valid (out_edge_valid),
  .out_last       (out_last)
);

`default_nettype wire
